// ----- rtl/core/class_constrained_nearest_match_top_assert.svh -----
// assertion macros for the nearest match block checker
// depends on nothing; included by the checker module only
`ifndef CLASS_CONSTRAINED_NEAREST_MATCH_TOP_ASSERT_SVH
`define CLASS_CONSTRAINED_NEAREST_MATCH_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CNM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest match check failed");

// next-cycle implication, disabled during reset
`define CNM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest match check failed");

`endif

// ----- rtl/core/cnm_pkg.sv -----
// shared types, codes and sizes of the nearest match block
// depends on nothing; used by every module of the block but cnm_ram
package cnm_pkg;

    // reference table size and derived widths
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int COORD_W = 16;
    localparam int CLASS_W = 2;
    localparam int DIST_W  = 34;
    localparam int QIDX_W  = 16;
    localparam int RIDX_W  = 6;
    localparam int ENTRY_W = 2 * COORD_W + CLASS_W;
    localparam int SQ_W    = 2 * COORD_W;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic [0:0] REG_THRESH = 1'b0;
    localparam logic [DIST_W-1:0] THRESH_RESET = 34'd2055209;

    // input modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_MATCHED = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [CLASS_W-1:0]        class_label;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [RIDX_W-1:0] ref_index;
        logic [QIDX_W-1:0] query_index;
        logic [DIST_W-1:0] distance_sq;
    } t_out_item;

    // tag that travels with a table read
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_rd_tag;

    // one scored table entry from the distance unit
    typedef struct packed {
        logic              valid;
        logic              match;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_sq;
    } t_dist_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

endpackage

// ----- rtl/core/cnm_ram.sv -----
// generic single write port, single read port ram with registered read
// depends on nothing
module cnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/cnm_dist_unit.sv -----
// pipelined squared distance unit, one table entry per cycle
// depends on cnm_pkg
module cnm_dist_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cnm_pkg::t_rd_tag                 i_tag,
    input  logic [cnm_pkg::ENTRY_W-1:0]      i_entry,
    input  logic signed [cnm_pkg::COORD_W-1:0] i_qx,
    input  logic signed [cnm_pkg::COORD_W-1:0] i_qy,
    input  logic [cnm_pkg::CLASS_W-1:0]      i_qclass,
    output cnm_pkg::t_dist_res               o_res,
    output logic                             o_busy
);

    logic signed [cnm_pkg::COORD_W-1:0] w_rx;
    logic signed [cnm_pkg::COORD_W-1:0] w_ry;
    logic [cnm_pkg::CLASS_W-1:0]        w_rclass;
    logic signed [cnm_pkg::COORD_W:0]   n_dx;
    logic signed [cnm_pkg::COORD_W:0]   n_dy;
    logic signed [cnm_pkg::COORD_W:0]   r_dx;
    logic signed [cnm_pkg::COORD_W:0]   r_dy;
    logic signed [2*cnm_pkg::COORD_W+1:0] w_px;
    logic signed [2*cnm_pkg::COORD_W+1:0] w_py;
    logic [cnm_pkg::SQ_W-1:0]           r_sqx;
    logic [cnm_pkg::SQ_W-1:0]           r_sqy;
    logic [cnm_pkg::DIST_W-1:0]         r_dist;
    logic                               r_v1, r_v2, r_v3;
    logic                               r_m1, r_m2, r_m3;
    logic [cnm_pkg::IDX_W-1:0]          r_i1, r_i2, r_i3;

    // unpack the stored entry
    assign w_rx     = i_entry[cnm_pkg::COORD_W-1:0];
    assign w_ry     = i_entry[2*cnm_pkg::COORD_W-1:cnm_pkg::COORD_W];
    assign w_rclass = i_entry[cnm_pkg::ENTRY_W-1:2*cnm_pkg::COORD_W];

    // differences, sign extended by one bit so they never wrap
    assign n_dx = $signed({i_qx[cnm_pkg::COORD_W-1], i_qx}) -
                  $signed({w_rx[cnm_pkg::COORD_W-1], w_rx});
    assign n_dy = $signed({i_qy[cnm_pkg::COORD_W-1], i_qy}) -
                  $signed({w_ry[cnm_pkg::COORD_W-1], w_ry});

    // squares of the differences
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_tag.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // datapath stages: difference, square, sum
    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_m1   <= (w_rclass == i_qclass);
        r_i1   <= i_tag.idx;
        r_sqx  <= w_px[cnm_pkg::SQ_W-1:0];
        r_sqy  <= w_py[cnm_pkg::SQ_W-1:0];
        r_m2   <= r_m1;
        r_i2   <= r_i1;
        r_dist <= cnm_pkg::DIST_W'(r_sqx) + cnm_pkg::DIST_W'(r_sqy);
        r_m3   <= r_m2;
        r_i3   <= r_i2;
    end

    assign o_res.valid   = r_v3;
    assign o_res.match   = r_m3;
    assign o_res.idx     = r_i3;
    assign o_res.dist_sq = r_dist;
    assign o_busy        = r_v1 | r_v2 | r_v3;

endmodule

// ----- rtl/core/cnm_ctrl.sv -----
// sequencer: table fill, query scan, best-match tracking and result register
// depends on cnm_pkg
module cnm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cnm_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cnm_pkg::t_out_item            o_out_item,
    input  logic [cnm_pkg::DIST_W-1:0]    i_thresh,
    output logic                          o_wr_en,
    output logic [cnm_pkg::IDX_W-1:0]     o_wr_addr,
    output logic [cnm_pkg::ENTRY_W-1:0]   o_wr_data,
    output logic                          o_rd_en,
    output logic [cnm_pkg::IDX_W-1:0]     o_rd_addr,
    output cnm_pkg::t_rd_tag              o_rd_tag,
    output logic signed [cnm_pkg::COORD_W-1:0] o_qx,
    output logic signed [cnm_pkg::COORD_W-1:0] o_qy,
    output logic [cnm_pkg::CLASS_W-1:0]   o_qclass,
    input  cnm_pkg::t_dist_res            i_res,
    input  logic                          i_busy
);

    cnm_pkg::t_state                    r_state, n_state;
    logic [cnm_pkg::CNT_W-1:0]          r_count, n_count;
    logic [cnm_pkg::CNT_W-1:0]          r_issue, n_issue;
    logic [cnm_pkg::QIDX_W-1:0]         r_qcnt, n_qcnt;
    logic [cnm_pkg::DIST_W-1:0]         r_best, n_best;
    logic [cnm_pkg::IDX_W-1:0]          r_best_idx, n_best_idx;
    logic                               r_found, n_found;
    logic signed [cnm_pkg::COORD_W-1:0] r_qx, n_qx;
    logic signed [cnm_pkg::COORD_W-1:0] r_qy, n_qy;
    logic [cnm_pkg::CLASS_W-1:0]        r_qclass, n_qclass;
    logic                               r_out_valid, n_out_valid;
    cnm_pkg::t_out_item                 r_out_item, n_out_item;
    cnm_pkg::t_rd_tag                   r_rd_tag, n_rd_tag;
    logic                               w_accept;

    // input is taken only when idle and the result slot frees up
    assign o_in_ready = (r_state == cnm_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // table ports
    assign o_wr_addr = r_count[cnm_pkg::IDX_W-1:0];
    assign o_wr_data = {i_in_item.class_label, i_in_item.coord_y, i_in_item.coord_x};
    assign o_rd_addr = r_issue[cnm_pkg::IDX_W-1:0];

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_qcnt      = r_qcnt;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_found     = r_found;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_qclass    = r_qclass;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        n_rd_tag    = '0;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // keep the strictly closer same-class entry, lowest index on ties
        if (i_res.valid && i_res.match && (i_res.dist_sq < r_best)) begin
            n_best     = i_res.dist_sq;
            n_best_idx = i_res.idx;
            n_found    = 1'b1;
        end

        unique case (r_state)
            cnm_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_item.mode)
                        cnm_pkg::MODE_CLEAR: begin
                            n_count     = '0;
                            n_qcnt      = '0;
                            n_out_valid = 1'b1;
                            n_out_item  = '0;
                        end
                        cnm_pkg::MODE_LOAD: begin
                            n_out_valid = 1'b1;
                            n_out_item  = '0;
                            if (r_count == cnm_pkg::CNT_W'(cnm_pkg::TABLE_DEPTH)) begin
                                n_out_item.status = cnm_pkg::ST_DROPPED;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        cnm_pkg::MODE_QUERY: begin
                            n_qx       = i_in_item.coord_x;
                            n_qy       = i_in_item.coord_y;
                            n_qclass   = i_in_item.class_label;
                            n_best     = i_thresh;
                            n_best_idx = '0;
                            n_found    = 1'b0;
                            n_issue    = '0;
                            n_state    = (r_count == '0) ? cnm_pkg::S_FIN : cnm_pkg::S_SCAN;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_item  = '0;
                        end
                    endcase
                end
            end
            cnm_pkg::S_SCAN: begin
                // one table read per cycle
                o_rd_en        = 1'b1;
                n_rd_tag.valid = 1'b1;
                n_rd_tag.idx   = r_issue[cnm_pkg::IDX_W-1:0];
                n_issue        = r_issue + 1'b1;
                if (n_issue == r_count) begin
                    n_state = cnm_pkg::S_DRAIN;
                end
            end
            cnm_pkg::S_DRAIN: begin
                if (!r_rd_tag.valid && !i_busy) begin
                    n_state = cnm_pkg::S_FIN;
                end
            end
            cnm_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out_item.query_index = r_qcnt;
                    n_qcnt                 = r_qcnt + 1'b1;
                    if (r_found) begin
                        n_out_item.status      = cnm_pkg::ST_MATCHED;
                        n_out_item.ref_index   = cnm_pkg::RIDX_W'(r_best_idx);
                        n_out_item.distance_sq = r_best;
                    end else begin
                        n_out_item.status      = cnm_pkg::ST_NOMATCH;
                        n_out_item.ref_index   = '0;
                        n_out_item.distance_sq = '0;
                    end
                    n_state = cnm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cnm_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cnm_pkg::S_IDLE;
            r_count     <= '0;
            r_qcnt      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_tag    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_qcnt      <= n_qcnt;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_rd_tag    <= n_rd_tag;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_issue    <= n_issue;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_qx       <= n_qx;
        r_qy       <= n_qy;
        r_qclass   <= n_qclass;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_rd_tag    = r_rd_tag;
    assign o_qx        = r_qx;
    assign o_qy        = r_qy;
    assign o_qclass    = r_qclass;

endmodule

// ----- rtl/core/class_constrained_nearest_match_top.sv -----
// Class-constrained nearest match. Reference points are loaded into a table of
// cnm_pkg::TABLE_DEPTH entries held in a RAM with a registered read port. A clear,
// load or unused transaction is handled at its accepting edge, and its result is
// valid from the cycle right after that edge. A query transaction scans the table
// through the RAM read port one entry per cycle into a shared pipelined distance
// unit; its result is registered once the scan has ended and the read tag and the
// distance pipeline have drained, and an empty table skips the scan altogether.
// The input is ready only while no query is in progress and the result slot is
// free or being emptied, so one transaction finishes before the next is taken.
// The squared threshold register sits at APB address 0.
// top level: apb register, sequencer, table ram and distance unit
// depends on cnm_pkg, cnm_ram, cnm_dist_unit, cnm_ctrl
module class_constrained_nearest_match_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  cnm_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output cnm_pkg::t_out_item               o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cnm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cnm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cnm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [cnm_pkg::DIST_W-1:0]         r_thresh;
    logic                               w_sel_thresh;
    logic                               w_wr_en;
    logic [cnm_pkg::IDX_W-1:0]          w_wr_addr;
    logic [cnm_pkg::ENTRY_W-1:0]        w_wr_data;
    logic                               w_rd_en;
    logic [cnm_pkg::IDX_W-1:0]          w_rd_addr;
    logic [cnm_pkg::ENTRY_W-1:0]        w_rd_data;
    cnm_pkg::t_rd_tag                   w_rd_tag;
    logic signed [cnm_pkg::COORD_W-1:0] w_qx;
    logic signed [cnm_pkg::COORD_W-1:0] w_qy;
    logic [cnm_pkg::CLASS_W-1:0]        w_qclass;
    cnm_pkg::t_dist_res                 w_res;
    logic                               w_busy;

    // apb register decode, 8-byte spacing
    assign w_sel_thresh = (paddr[cnm_pkg::APB_ADDR_W-1:3] == cnm_pkg::REG_THRESH);
    assign pready       = 1'b1;
    assign prdata       = w_sel_thresh ? cnm_pkg::APB_DATA_W'(r_thresh) : '0;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= cnm_pkg::THRESH_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_thresh) begin
            r_thresh <= pwdata[cnm_pkg::DIST_W-1:0];
        end
    end

    cnm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_thresh    (r_thresh),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .o_rd_tag    (w_rd_tag),
        .o_qx        (w_qx),
        .o_qy        (w_qy),
        .o_qclass    (w_qclass),
        .i_res       (w_res),
        .i_busy      (w_busy)
    );

    cnm_ram #(
        .WIDTH (cnm_pkg::ENTRY_W),
        .DEPTH (cnm_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    cnm_dist_unit u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_rd_tag),
        .i_entry  (w_rd_data),
        .i_qx     (w_qx),
        .i_qy     (w_qy),
        .i_qclass (w_qclass),
        .o_res    (w_res),
        .o_busy   (w_busy)
    );

endmodule

// ----- rtl/core/cnm_checker.sv -----
// port-level checker for the nearest match block, bound to the top level
// depends on cnm_pkg and class_constrained_nearest_match_top_assert.svh
`include "class_constrained_nearest_match_top_assert.svh"

module cnm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input cnm_pkg::t_in_item              i_in_item,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input cnm_pkg::t_out_item             o_out_item
);

    logic w_in_accept;
    logic w_in_query;

    // input handshake and query decode
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_in_query  = (i_in_item.mode == cnm_pkg::MODE_QUERY);

    // a stalled result stays valid and unchanged
    `CNM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `CNM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_item))

    // clear, load and unused transactions answer on the next cycle
    `CNM_ASSERT_NEXT(a_quick_result, i_clk, i_rst_n, w_in_accept && !w_in_query, o_out_valid)

    // a query keeps the input closed while the table is scanned
    `CNM_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_in_accept && w_in_query, !o_in_ready)

endmodule

bind class_constrained_nearest_match_top cnm_checker u_cnm_checker (.*);

// ----- verif/class_constrained_nearest_match_top_tb.sv -----
// self-checking testbench for the class-constrained nearest match block
// depends on cnm_pkg and class_constrained_nearest_match_top; drives both streams and apb
module class_constrained_nearest_match_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [cnm_pkg::APB_ADDR_W-1:0] THRESH_ADDR =
        cnm_pkg::APB_ADDR_W'(8 * cnm_pkg::REG_THRESH);
    localparam logic [cnm_pkg::APB_DATA_W-1:0] THRESH_MAX =
        cnm_pkg::APB_DATA_W'({cnm_pkg::DIST_W{1'b1}});
    localparam int SETTLE_CYCLES   = 4;
    localparam int ITEMS_PER_PHASE = 176;
    localparam int DRAIN_LIMIT     = 200000;
    localparam int CYCLE_LIMIT     = 4000000;

    // block ports
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    cnm_pkg::t_in_item              i_in_item = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    cnm_pkg::t_out_item             o_out_item;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [cnm_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [cnm_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [cnm_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // predicted copy of the table, query count and threshold
    logic signed [cnm_pkg::COORD_W-1:0] pt_x [cnm_pkg::TABLE_DEPTH];
    logic signed [cnm_pkg::COORD_W-1:0] pt_y [cnm_pkg::TABLE_DEPTH];
    logic [cnm_pkg::CLASS_W-1:0]        pt_class [cnm_pkg::TABLE_DEPTH];
    int unsigned                        pt_count = 0;
    logic [cnm_pkg::QIDX_W-1:0]         query_seq = '0;
    logic [cnm_pkg::DIST_W-1:0]         thresh_sq = cnm_pkg::THRESH_RESET;

    cnm_pkg::t_out_item due_results [$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    class_constrained_nearest_match_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // nearest same-class point under the threshold; updates the predicted table
    function automatic cnm_pkg::t_out_item predict_match(cnm_pkg::t_in_item it);
        cnm_pkg::t_out_item r;
        longint             dx, dy;
        longint unsigned    d, best;
        logic               found;
        int unsigned        best_i;
        r = '0;
        unique case (it.mode)
            cnm_pkg::MODE_CLEAR: begin
                pt_count = 0;
                query_seq = '0;
                r.status = cnm_pkg::ST_DONE;
            end
            cnm_pkg::MODE_LOAD: begin
                if (pt_count < cnm_pkg::TABLE_DEPTH) begin
                    pt_x[pt_count] = it.coord_x;
                    pt_y[pt_count] = it.coord_y;
                    pt_class[pt_count] = it.class_label;
                    pt_count++;
                    r.status = cnm_pkg::ST_DONE;
                end else begin
                    r.status = cnm_pkg::ST_DROPPED;
                end
            end
            cnm_pkg::MODE_QUERY: begin
                best = thresh_sq;
                found = 1'b0;
                best_i = 0;
                for (int i = 0; i < pt_count; i++) begin
                    if (pt_class[i] == it.class_label) begin
                        dx = longint'($signed(it.coord_x)) - longint'($signed(pt_x[i]));
                        dy = longint'($signed(it.coord_y)) - longint'($signed(pt_y[i]));
                        d = dx * dx + dy * dy;
                        // strict compare keeps the lowest index on ties
                        if (d < best) begin
                            best = d;
                            best_i = i;
                            found = 1'b1;
                        end
                    end
                end
                r.query_index = query_seq;
                query_seq++;
                if (found) begin
                    r.status = cnm_pkg::ST_MATCHED;
                    r.ref_index = cnm_pkg::RIDX_W'(best_i);
                    r.distance_sq = best[cnm_pkg::DIST_W-1:0];
                end else begin
                    r.status = cnm_pkg::ST_NOMATCH;
                end
            end
            default: r.status = cnm_pkg::ST_DONE;
        endcase
        return r;
    endfunction

    function automatic cnm_pkg::t_in_item make_item(logic [1:0] m,
                                                    logic [cnm_pkg::COORD_W-1:0] x,
                                                    logic [cnm_pkg::COORD_W-1:0] y,
                                                    logic [cnm_pkg::CLASS_W-1:0] c);
        cnm_pkg::t_in_item it;
        it.mode = m;
        it.coord_x = x;
        it.coord_y = y;
        it.class_label = c;
        return it;
    endfunction

    // mostly loads and queries near stored points, some clears and unused modes
    function automatic cnm_pkg::t_in_item random_item();
        cnm_pkg::t_in_item it;
        int unsigned       pick, k;
        pick = $urandom_range(99);
        it.mode = cnm_pkg::MODE_QUERY;
        it.coord_x = cnm_pkg::COORD_W'($urandom);
        it.coord_y = cnm_pkg::COORD_W'($urandom);
        it.class_label = cnm_pkg::CLASS_W'($urandom_range(3));
        if (pick < 2) begin
            it.mode = cnm_pkg::MODE_CLEAR;
        end else if (pick < 4) begin
            it.mode = MODE_UNUSED;
        end else if (pick < 42) begin
            it.mode = cnm_pkg::MODE_LOAD;
            if ($urandom_range(1) == 0) begin
                it.coord_x = cnm_pkg::COORD_W'($urandom_range(8191)) - cnm_pkg::COORD_W'(4096);
                it.coord_y = cnm_pkg::COORD_W'($urandom_range(8191)) - cnm_pkg::COORD_W'(4096);
            end
        end else if (pt_count != 0 && $urandom_range(3) != 0) begin
            k = $urandom_range(pt_count - 1);
            it.coord_x = pt_x[k] + cnm_pkg::COORD_W'($urandom_range(3000))
                         - cnm_pkg::COORD_W'(1500);
            it.coord_y = pt_y[k] + cnm_pkg::COORD_W'($urandom_range(3000))
                         - cnm_pkg::COORD_W'(1500);
            if ($urandom_range(4) != 0)
                it.class_label = pt_class[k];
        end
        return it;
    endfunction

    function automatic logic [cnm_pkg::APB_DATA_W-1:0] random_threshold();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return cnm_pkg::APB_DATA_W'($urandom_range(4000000));
            2: return cnm_pkg::APB_DATA_W'(1) << $urandom_range(cnm_pkg::DIST_W - 1);
            default: return cnm_pkg::APB_DATA_W'(cnm_pkg::THRESH_RESET);
        endcase
    endfunction

    // one input transaction, with a random gap afterwards
    task automatic send_item(cnm_pkg::t_in_item it);
        cnm_pkg::t_out_item exp_res;
        exp_res = predict_match(it);
        due_results = {due_results, exp_res};
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // hold input until every outstanding result is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup and access phase on the register port
    task automatic apb_xfer(input logic wr, input logic [cnm_pkg::APB_DATA_W-1:0] wdata,
                            output logic [cnm_pkg::APB_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= THRESH_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_thresh_reg();
        logic [cnm_pkg::APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, '0, rd);
        if (rd !== cnm_pkg::APB_DATA_W'(thresh_sq)) begin
            $error("dist_threshold_sq: expected %0d, got %0d", thresh_sq, rd);
            error_count++;
        end
    endtask

    task automatic set_thresh(logic [cnm_pkg::APB_DATA_W-1:0] v);
        logic [cnm_pkg::APB_DATA_W-1:0] rd;
        wait_idle();
        apb_xfer(1'b1, v, rd);
        thresh_sq = v[cnm_pkg::DIST_W-1:0];
        check_thresh_reg();
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin : result_check
        cnm_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $error("result transaction with nothing expected: %p", o_out_item);
                error_count++;
            end else begin
                want = due_results.pop_front();
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                    error_count++;
                end
                if (o_out_item.ref_index !== want.ref_index) begin
                    $error("ref_index: expected %0d, got %0d",
                           want.ref_index, o_out_item.ref_index);
                    error_count++;
                end
                if (o_out_item.query_index !== want.query_index) begin
                    $error("query_index: expected %0d, got %0d",
                           want.query_index, o_out_item.query_index);
                    error_count++;
                end
                if (o_out_item.distance_sq !== want.distance_sq) begin
                    $error("distance_sq: expected %0d, got %0d",
                           want.distance_sq, o_out_item.distance_sq);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_reset_value();
        check_thresh_reg();
    endtask

    // field extremes, ties, class filter and the strict threshold
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_thresh(THRESH_MAX);
        send_item(make_item(MODE_UNUSED, 16'h7FFF, 16'hFFFF, 2'd3));
        send_item(make_item(cnm_pkg::MODE_CLEAR, 16'h0000, 16'h0000, 2'd0));
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'h0000, 16'h0000, 2'd0));
        // largest possible distance still below the largest threshold
        send_item(make_item(cnm_pkg::MODE_LOAD, 16'h8000, 16'h8000, 2'd0));
        send_item(make_item(cnm_pkg::MODE_LOAD, 16'h7FFF, 16'h7FFF, 2'd1));
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'h7FFF, 16'h7FFF, 2'd0));
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'h8000, 16'h8000, 2'd1));
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'h0000, 16'h0000, 2'd2));
        // duplicate points, exact hit
        send_item(make_item(cnm_pkg::MODE_LOAD, 16'd100, -16'sd200, 2'd2));
        send_item(make_item(cnm_pkg::MODE_LOAD, 16'd100, -16'sd200, 2'd2));
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'd100, -16'sd200, 2'd2));
        // equidistant points on either side
        send_item(make_item(cnm_pkg::MODE_LOAD, 16'd300, 16'd0, 2'd3));
        send_item(make_item(cnm_pkg::MODE_LOAD, -16'sd300, 16'd0, 2'd3));
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'd0, 16'd0, 2'd3));
        // zero threshold never matches
        set_thresh('0);
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'd100, -16'sd200, 2'd2));
        // distance equal to threshold, then one above
        set_thresh(cnm_pkg::APB_DATA_W'(90000));
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'd0, 16'd0, 2'd3));
        set_thresh(cnm_pkg::APB_DATA_W'(90001));
        send_item(make_item(cnm_pkg::MODE_QUERY, 16'd0, 16'd0, 2'd3));
    endtask

    // fill the table, overflow it and scan all entries
    task automatic test_table_full();
        cnm_pkg::t_in_item it;
        set_thresh(random_threshold());
        send_idle_pct = 14;
        recv_stall_pct = 14;
        send_item(make_item(cnm_pkg::MODE_CLEAR, 16'd0, 16'd0, 2'd0));
        for (int n = 0; n < cnm_pkg::TABLE_DEPTH + 3; n++) begin
            it = random_item();
            it.mode = cnm_pkg::MODE_LOAD;
            send_item(it);
            if (n % 8 == 7) begin
                it = random_item();
                it.mode = cnm_pkg::MODE_QUERY;
                send_item(it);
            end
        end
        send_item(make_item(cnm_pkg::MODE_QUERY, pt_x[cnm_pkg::TABLE_DEPTH-1],
                            pt_y[cnm_pkg::TABLE_DEPTH-1], pt_class[cnm_pkg::TABLE_DEPTH-1]));
    endtask

    // random traffic under several idle and stall mixes
    task automatic test_random_traffic();
        for (int ph = 0; ph < 5; ph++) begin
            set_thresh(ph == 0 ? cnm_pkg::APB_DATA_W'(cnm_pkg::THRESH_RESET)
                               : random_threshold());
            case (ph)
                1: begin send_idle_pct = 87; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 87; end
                3: begin send_idle_pct = 14; recv_stall_pct = 14; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_item());
                // let the block drain completely once mid-stream
                if (ph == 1 && n == ITEMS_PER_PHASE / 2)
                    wait_idle();
            end
        end
    endtask

    initial begin
        int waited;
        waited = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_value();
        test_directed();
        test_table_full();
        test_random_traffic();

        // drain and let the pipeline settle
        i_in_valid <= 1'b0;
        while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (cnm_pkg::TABLE_DEPTH + 10) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- class_constrained_nearest_match_top.f -----
+incdir+rtl/core
rtl/core/cnm_pkg.sv
rtl/core/cnm_ram.sv
rtl/core/cnm_dist_unit.sv
rtl/core/cnm_ctrl.sv
rtl/core/class_constrained_nearest_match_top.sv
rtl/core/cnm_checker.sv
verif/class_constrained_nearest_match_top_tb.sv
